[rtl/dts_pkg.sv]
// shared types and codes for the depth-first topological sort block
package dts_pkg;

  localparam int unsigned NODE_W = 7;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  localparam logic [1:0] MARK_NEW  = 2'd0;
  localparam logic [1:0] MARK_OPEN = 2'd1;
  localparam logic [1:0] MARK_DONE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROOT,
    ST_ROOT_CHK,
    ST_SCAN,
    ST_EDGE,
    ST_MARK,
    ST_POP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

endpackage

[rtl/dts_ram.sv]
// simple dual-port memory, one write port and one registered read port
module dts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dfs_topological_sort.sv]
// top level: edge loader, depth-first walk sequencer and result emitter
//
// Edges are loaded one beat per cycle (tuser = 0) into an edge memory in
// arrival order; edges beyond MAX_EDGES are dropped and flagged. A solve beat
// (tuser = 1) runs an iterative depth-first search with an explicit stack.
// Node marks, the stack and the postorder list each sit in a synchronous
// memory with a registered read port. A solve clears all MAX_NODES marks,
// then tries each root, scans the stored edges for each node (reading the
// target mark on a hit), and finishes each node into the postorder list;
// the walk is bound by the single read port of the edge memory. Results
// then leave in reverse postorder, each read only once the last is taken.
// On a cycle one beat with node 0 and the impossible flag comes out. The input
// stays stalled from the solve beat until the last result beat is taken.
module dfs_topological_sort #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: node_count
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // from_node[6:0], to_node[13:7], zero pad
  input  logic        s_axis_tuser,   // command
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // node[6:0], zero pad
  output logic [1:0]  m_axis_tuser,   // impossible, overflow
  output logic        m_axis_tlast
);
  import dts_pkg::*;

  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NAW = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned SW  = NODE_W + EW;

  state_e state_q, state_d;

  logic [6:0]        node_cnt_q;
  logic [EW-1:0]     edge_total_q, edge_total_d;
  logic              dropped_q, dropped_d;
  logic              ovf_q, ovf_d;
  logic [NODE_W-1:0] root_q, root_d;
  logic [NODE_W-1:0] cur_u_q, cur_u_d;
  logic [EW-1:0]     cur_e_q, cur_e_d;
  logic [NCW-1:0]    depth_q, depth_d;
  logic [NCW-1:0]    plen_q, plen_d;
  logic [NAW-1:0]    idx_q, idx_d;
  logic [NODE_W-1:0] tgt_q, tgt_d;
  logic              out_valid_q, out_valid_d;
  logic [NODE_W-1:0] out_node_q, out_node_d;
  logic              out_imp_q, out_imp_d;
  logic              out_last_q, out_last_d;

  // node count clamped into 1..MAX_NODES
  logic [NODE_W-1:0] n_eff;
  always_comb begin
    if (node_cnt_q == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_cnt_q > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = node_cnt_q;
    end
  end

  logic in_beat, out_beat;
  assign in_beat  = s_axis_tvalid & s_axis_tready;
  assign out_beat = m_axis_tvalid & m_axis_tready;

  // edge store
  logic          edge_we;
  logic [SW-1:0] unused_sw;
  logic [13:0]   edge_rdata;
  logic [NODE_W-1:0] e_src, e_tgt;
  assign edge_we = in_beat & (s_axis_tuser == CMD_ADD) &
                   (edge_total_q < EW'(MAX_EDGES));
  assign e_src = edge_rdata[6:0];
  assign e_tgt = edge_rdata[13:7];
  assign unused_sw = '0;

  dts_ram #(.Width(14), .Depth(MAX_EDGES), .AddrW(EAW)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_total_q[EAW-1:0]),
    .wdata_i (s_axis_tdata[13:0]),
    .raddr_i (cur_e_q[EAW-1:0]),
    .rdata_o (edge_rdata)
  );

  // mark, stack and postorder memories
  logic           mark_we;
  logic [NAW-1:0] mark_waddr, mark_raddr;
  logic [1:0]     mark_wdata, mark_rdata;
  logic           stk_we;
  logic [NAW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0]  stk_wdata, stk_rdata;
  logic           post_we;
  logic [NODE_W-1:0] post_rdata;

  dts_ram #(.Width(2), .Depth(MAX_NODES), .AddrW(NAW)) u_mark_ram (
    .clk_i (clk_i), .we_i (mark_we), .waddr_i (mark_waddr), .wdata_i (mark_wdata),
    .raddr_i (mark_raddr), .rdata_o (mark_rdata)
  );

  dts_ram #(.Width(SW), .Depth(MAX_NODES), .AddrW(NAW)) u_stack_ram (
    .clk_i (clk_i), .we_i (stk_we), .waddr_i (stk_waddr), .wdata_i (stk_wdata),
    .raddr_i (stk_raddr), .rdata_o (stk_rdata)
  );

  dts_ram #(.Width(NODE_W), .Depth(MAX_NODES), .AddrW(NAW)) u_post_ram (
    .clk_i (clk_i), .we_i (post_we), .waddr_i (plen_q[NAW-1:0]), .wdata_i (cur_u_q),
    .raddr_i (idx_q), .rdata_o (post_rdata)
  );

  // edge fetched in ST_EDGE counts only if it leaves cur_u toward a live node
  logic edge_hit;
  assign edge_hit = (e_src == cur_u_q) && (e_tgt != '0) && (e_tgt <= n_eff);

  // next state and register updates
  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    dropped_d    = dropped_q;
    ovf_d        = ovf_q;
    root_d       = root_q;
    cur_u_d      = cur_u_q;
    cur_e_d      = cur_e_q;
    depth_d      = depth_q;
    plen_d       = plen_q;
    idx_d        = idx_q;
    tgt_d        = tgt_q;
    out_valid_d  = out_valid_q;
    out_node_d   = out_node_q;
    out_imp_d    = out_imp_q;
    out_last_d   = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser == CMD_ADD) begin
            if (edge_total_q < EW'(MAX_EDGES)) begin
              edge_total_d = edge_total_q + EW'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end else begin
            ovf_d     = dropped_q;
            dropped_d = 1'b0;
            idx_d     = '0;
            plen_d    = '0;
            state_d   = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        idx_d = idx_q + NAW'(1);
        if (idx_q == NAW'(MAX_NODES - 1)) begin
          root_d  = NODE_W'(1);
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_q > n_eff) begin
          edge_total_d = '0;
          idx_d        = NAW'(plen_q - NCW'(1));
          state_d      = ST_EMIT_RD;
        end else begin
          state_d = ST_ROOT_CHK;
        end
      end
      ST_ROOT_CHK: begin
        if (mark_rdata != MARK_NEW) begin
          root_d  = root_q + NODE_W'(1);
          state_d = ST_ROOT;
        end else begin
          cur_u_d = root_q;
          cur_e_d = '0;
          depth_d = NCW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cur_e_q < edge_total_q) begin
          state_d = ST_EDGE;
        end else begin
          plen_d  = plen_q + NCW'(1);
          depth_d = depth_q - NCW'(1);
          if (depth_q == NCW'(1)) begin
            root_d  = root_q + NODE_W'(1);
            state_d = ST_ROOT;
          end else begin
            state_d = ST_POP;
          end
        end
      end
      ST_EDGE: begin
        cur_e_d = cur_e_q + EW'(1);
        tgt_d   = e_tgt;
        state_d = edge_hit ? ST_MARK : ST_SCAN;
      end
      ST_MARK: begin
        if (mark_rdata == MARK_OPEN) begin
          // back edge: one impossible beat
          edge_total_d = '0;
          out_valid_d  = 1'b1;
          out_node_d   = '0;
          out_imp_d    = 1'b1;
          out_last_d   = 1'b1;
          state_d      = ST_EMIT_WAIT;
        end else if (mark_rdata == MARK_NEW) begin
          cur_u_d = tgt_q;
          cur_e_d = '0;
          depth_d = depth_q + NCW'(1);
          state_d = ST_SCAN;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_POP: begin
        cur_u_d = stk_rdata[NODE_W-1:0];
        cur_e_d = stk_rdata[SW-1:NODE_W];
        state_d = ST_SCAN;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_node_d  = post_rdata;
        out_imp_d   = 1'b0;
        out_last_d  = (idx_q == '0);
        state_d     = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_beat) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - NAW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // memory strobes per state
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = idx_q;
    mark_wdata = MARK_NEW;
    mark_raddr = NAW'(root_q - NODE_W'(1));
    stk_we     = 1'b0;
    stk_waddr  = NAW'(depth_q - NCW'(1));
    stk_wdata  = {cur_e_q, cur_u_q};
    stk_raddr  = NAW'(depth_q - NCW'(2));
    post_we    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mark_we = 1'b1;
      end
      ST_ROOT_CHK: begin
        if (mark_rdata == MARK_NEW) begin
          mark_we    = 1'b1;
          mark_waddr = NAW'(root_q - NODE_W'(1));
          mark_wdata = MARK_OPEN;
        end
      end
      ST_SCAN: begin
        if (!(cur_e_q < edge_total_q)) begin
          mark_we    = 1'b1;
          mark_waddr = NAW'(cur_u_q - NODE_W'(1));
          mark_wdata = MARK_DONE;
          post_we    = 1'b1;
        end
      end
      ST_EDGE: begin
        mark_raddr = NAW'(e_tgt - NODE_W'(1));
      end
      ST_MARK: begin
        if (mark_rdata == MARK_NEW) begin
          // save the parent with its cursor already past this edge
          mark_we    = 1'b1;
          mark_waddr = NAW'(tgt_q - NODE_W'(1));
          mark_wdata = MARK_OPEN;
          stk_we     = 1'b1;
        end
      end
      default: begin
        mark_we = 1'b0;
      end
    endcase
    stk_wdata = stk_wdata | unused_sw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_cnt_q   <= 7'd1;
      edge_total_q <= '0;
      dropped_q    <= 1'b0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      root_q       <= '0;
      depth_q      <= '0;
      plen_q       <= '0;
      idx_q        <= '0;
      cur_e_q      <= '0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      dropped_q    <= dropped_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
      root_q       <= root_d;
      depth_q      <= depth_d;
      plen_q       <= plen_d;
      idx_q        <= idx_d;
      cur_e_q      <= cur_e_d;
      if (cfg_valid_i) begin
        node_cnt_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_u_q    <= cur_u_d;
    tgt_q      <= tgt_d;
    out_node_q <= out_node_d;
    out_imp_q  <= out_imp_d;
    out_last_q <= out_last_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_node_q};
  assign m_axis_tuser  = {ovf_q, out_imp_q};
  assign m_axis_tlast  = out_last_q;

  // result beats only come out of the wait state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == ST_EMIT_WAIT))
    else $error("result valid outside the emit wait state");

  // a cycle report is always the single and final beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_imp_q) |-> (out_last_q && out_node_q == '0))
    else $error("impossible beat must be last with node zero");

  // stack never grows past the active node count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (depth_q != '0 && NODE_W'(depth_q) <= n_eff))
    else $error("walk depth out of range");

  // the edge store is empty once a solve has emitted its last beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && out_last_q) |=> (edge_total_q == '0 && !dropped_q))
    else $error("edge store not emptied after solve");

endmodule
